### rtl/core/drt_pkg.sv
package drt_pkg;

	// Field widths of the request and result.
	localparam int unsigned OP_W     = 2;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned COORD_W  = 16;
	localparam int unsigned CORNER_W = 18;
	localparam int unsigned SIZE_W   = 17;

	// Corner values of a slot that holds no box.
	localparam logic signed [CORNER_W-1:0] EMPTY_MIN = 18'sd100000;
	localparam logic signed [CORNER_W-1:0] EMPTY_MAX = -18'sd1;

	// Operation codes; the fourth code is ignored.
	typedef enum logic [OP_W-1:0] {
		OP_MARK  = 2'd0,
		OP_TAKE  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	typedef logic signed [CORNER_W-1:0] corner_t;

	// One stored box.
	typedef struct packed {
		corner_t min_x;
		corner_t min_y;
		corner_t max_x;
		corner_t max_y;
	} box_t;

	localparam int unsigned BOX_W = $bits(box_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

endpackage

### rtl/core/dirty_rect_tracker_top.sv
// A request is captured on accept, when the box table is also read; it
// commits in the execute state, which updates the table and the result
// register, and a waiting result holds off that commit. A new request is
// taken once the previous one has committed, even while its result waits.
// Reset (arst_n, asynchronous) marks every slot clean, which reads as the
// empty box; no clearing pass is needed and the block is ready at once.
module dirty_rect_tracker_top
	import drt_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OP_W-1:0]            operation,
	input  logic [SLOT_W-1:0]          slot,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	input  logic signed [COORD_W-1:0]  width,
	input  logic signed [COORD_W-1:0]  height,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       was_dirty,
	output logic signed [CORNER_W-1:0] rect_x,
	output logic signed [CORNER_W-1:0] rect_y,
	output logic [SIZE_W-1:0]          rect_width,
	output logic [SIZE_W-1:0]          rect_height
);

	cmd_t cmd;

	// Sequencing and handshake.
	drt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Box table and result computation.
	drt_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (operation),
		.slot        (slot),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.width       (width),
		.height      (height),
		.was_dirty   (was_dirty),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height)
	);

endmodule

### rtl/core/drt_ram.sv
module drt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/drt_ctrl.sv
module drt_ctrl
	import drt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// A request is taken only while no other one is being worked on.
	assign in_ready   = (state_q == S_IDLE);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.commit = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while pending");

	// An accepted request keeps the block busy, so no second one is accepted straight after it.
	a_load_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (!in_ready && !cmd.load))
		else $error("second request accepted while one is in flight");

endmodule

### rtl/core/drt_datapath.sv
module drt_datapath
	import drt_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	input  logic [OP_W-1:0]            operation,
	input  logic [SLOT_W-1:0]          slot,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	input  logic signed [COORD_W-1:0]  width,
	input  logic signed [COORD_W-1:0]  height,
	output logic                       was_dirty,
	output logic signed [CORNER_W-1:0] rect_x,
	output logic signed [CORNER_W-1:0] rect_y,
	output logic [SIZE_W-1:0]          rect_width,
	output logic [SIZE_W-1:0]          rect_height
);

	localparam int unsigned IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned SEXT_W = 9;

	logic [SEXT_W-1:0]          slot_wide;
	logic [IDX_W-1:0]           in_addr;
	logic                       in_slot_ok;

	logic [OP_W-1:0]            op_q;
	logic [IDX_W-1:0]           addr_q;
	logic                       slot_ok_q;
	logic signed [COORD_W-1:0]  x_q;
	logic signed [COORD_W-1:0]  y_q;
	logic signed [COORD_W-1:0]  w_q;
	logic signed [COORD_W-1:0]  h_q;

	logic [NUM_SLOTS-1:0]       dirty_q;
	logic [BOX_W-1:0]           rd_bits;
	box_t                       rd_box;
	box_t                       new_box;

	logic                       cur_dirty;
	corner_t                    eff_min_x;
	corner_t                    eff_min_y;
	corner_t                    eff_max_x;
	corner_t                    eff_max_y;
	corner_t                    x_ext;
	corner_t                    y_ext;
	corner_t                    end_x;
	corner_t                    end_y;
	corner_t                    diff_x;
	corner_t                    diff_y;
	logic                       mark_ok;
	logic                       take_hit;
	logic                       do_reset_slot;

	logic                       was_dirty_q;
	corner_t                    rect_x_q;
	corner_t                    rect_y_q;
	logic [SIZE_W-1:0]          rect_width_q;
	logic [SIZE_W-1:0]          rect_height_q;

	// Slot range check and table address.
	assign slot_wide  = SEXT_W'(slot);
	assign in_slot_ok = (slot_wide < SEXT_W'(NUM_SLOTS));
	assign in_addr    = slot_wide[IDX_W-1:0];

	// Capture the request on accept.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= operation;
			addr_q    <= in_addr;
			slot_ok_q <= in_slot_ok;
			x_q       <= pos_x;
			y_q       <= pos_y;
			w_q       <= width;
			h_q       <= height;
		end
	end

	// Box table; read on accept, written when a mark commits.
	drt_ram #(
		.WIDTH (BOX_W),
		.DEPTH (NUM_SLOTS)
	) u_box_ram (
		.clk   (clk),
		.we    (cmd.commit && mark_ok),
		.waddr (addr_q),
		.wdata (new_box),
		.re    (cmd.load),
		.raddr (in_addr),
		.rdata (rd_bits)
	);

	assign rd_box = box_t'(rd_bits);

	// A clean slot reads as the empty box, whatever the table holds.
	assign cur_dirty = dirty_q[addr_q];
	assign eff_min_x = cur_dirty ? rd_box.min_x : EMPTY_MIN;
	assign eff_min_y = cur_dirty ? rd_box.min_y : EMPTY_MIN;
	assign eff_max_x = cur_dirty ? rd_box.max_x : EMPTY_MAX;
	assign eff_max_y = cur_dirty ? rd_box.max_y : EMPTY_MAX;

	// Grow the box to cover the marked rectangle.
	assign x_ext = CORNER_W'(x_q);
	assign y_ext = CORNER_W'(y_q);
	assign end_x = x_ext + CORNER_W'(w_q);
	assign end_y = y_ext + CORNER_W'(h_q);

	assign new_box.min_x = (x_ext < eff_min_x) ? x_ext : eff_min_x;
	assign new_box.min_y = (y_ext < eff_min_y) ? y_ext : eff_min_y;
	assign new_box.max_x = (end_x > eff_max_x) ? end_x : eff_max_x;
	assign new_box.max_y = (end_y > eff_max_y) ? end_y : eff_max_y;

	// Operation decode.
	assign mark_ok = (op_q == OP_MARK) && slot_ok_q
		&& (w_q > 16'sd0) && (h_q > 16'sd0);
	assign take_hit = (op_q == OP_TAKE) && slot_ok_q && cur_dirty;
	assign do_reset_slot = slot_ok_q && ((op_q == OP_TAKE) || (op_q == OP_CLEAR));

	assign diff_x = rd_box.max_x - rd_box.min_x;
	assign diff_y = rd_box.max_y - rd_box.min_y;

	// Dirty flags double as valid bits for the table entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
		end else if (cmd.commit) begin
			if (mark_ok) begin
				dirty_q[addr_q] <= 1'b1;
			end else if (do_reset_slot) begin
				dirty_q[addr_q] <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			was_dirty_q   <= take_hit;
			rect_x_q      <= take_hit ? rd_box.min_x : '0;
			rect_y_q      <= take_hit ? rd_box.min_y : '0;
			rect_width_q  <= take_hit ? diff_x[SIZE_W-1:0] : '0;
			rect_height_q <= take_hit ? diff_y[SIZE_W-1:0] : '0;
		end
	end

	assign was_dirty   = was_dirty_q;
	assign rect_x      = rect_x_q;
	assign rect_y      = rect_y_q;
	assign rect_width  = rect_width_q;
	assign rect_height = rect_height_q;

	// A take or clear leaves the slot clean.
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && do_reset_slot) |=> !dirty_q[$past(addr_q)])
		else $error("slot still dirty after take or clear");

	// Only a take can report a dirty slot.
	a_report_only_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (op_q != OP_TAKE)) |=> !was_dirty_q)
		else $error("dirty report on an operation other than take");

endmodule

### verif/dirty_rect_tracker_tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import drt_pkg::*;

	// The fourth operation code is not part of the package; the block ignores it.
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	localparam int unsigned NUM_SLOTS    = 16;
	localparam int          RANDOM_ITEMS = 1200;
	localparam int          HOLD_AT      = 400;
	localparam int          HOLD_CYCLES  = 250;
	localparam int          DRAIN_AT     = 800;
	localparam int          TAIL_CYCLES  = 8;
	localparam int          IDLE_LIMIT   = 4000;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [SLOT_W-1:0]  slot;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
	} request_t;

	typedef struct packed {
		logic                dirty;
		logic [CORNER_W-1:0] rx;
		logic [CORNER_W-1:0] ry;
		logic [SIZE_W-1:0]   rw;
		logic [SIZE_W-1:0]   rh;
	} report_t;

	typedef struct packed {
		request_t req;
		bit       typed;
		report_t  rep;
	} table_row_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_HALF,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [OP_W-1:0]            operation = '0;
	logic [SLOT_W-1:0]          slot = '0;
	logic signed [COORD_W-1:0]  pos_x = '0;
	logic signed [COORD_W-1:0]  pos_y = '0;
	logic signed [COORD_W-1:0]  width = '0;
	logic signed [COORD_W-1:0]  height = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       was_dirty;
	logic signed [CORNER_W-1:0] rect_x;
	logic signed [CORNER_W-1:0] rect_y;
	logic [SIZE_W-1:0]          rect_width;
	logic [SIZE_W-1:0]          rect_height;

	dirty_rect_tracker_top #(
		.NUM_SLOTS(NUM_SLOTS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.slot       (slot),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.width      (width),
		.height     (height),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.was_dirty  (was_dirty),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_width (rect_width),
		.rect_height(rect_height)
	);

	// Free-running clock with a 2 ns period.
	always #1 clk = ~clk;

	// Predicted copy of the dirty table.
	corner_t box_lo_x [NUM_SLOTS];
	corner_t box_lo_y [NUM_SLOTS];
	corner_t box_hi_x [NUM_SLOTS];
	corner_t box_hi_y [NUM_SLOTS];
	logic    box_marked [NUM_SLOTS];

	report_t    pending_reports[$];
	table_row_t stimulus_table[$];
	int         requests_accepted = 0;
	int         mismatches = 0;
	int         burst_left = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;

	function automatic void empty_box(int s);
		box_lo_x[s]   = EMPTY_MIN;
		box_lo_y[s]   = EMPTY_MIN;
		box_hi_x[s]   = EMPTY_MAX;
		box_hi_y[s]   = EMPTY_MAX;
		box_marked[s] = 1'b0;
	endfunction

	// Applies one request to the predicted table and returns the report it yields.
	function automatic report_t predict_report(request_t req);
		report_t rep;
		int      s;
		int      px, py, pw, ph;
		rep = '0;
		s   = int'(req.slot);
		px  = $signed(req.x);
		py  = $signed(req.y);
		pw  = $signed(req.w);
		ph  = $signed(req.h);
		case (req.op)
			OP_MARK: begin
				if (pw > 0 && ph > 0) begin
					if (px < box_lo_x[s]) box_lo_x[s] = corner_t'(px);
					if (py < box_lo_y[s]) box_lo_y[s] = corner_t'(py);
					if (px + pw > box_hi_x[s]) box_hi_x[s] = corner_t'(px + pw);
					if (py + ph > box_hi_y[s]) box_hi_y[s] = corner_t'(py + ph);
					box_marked[s] = 1'b1;
				end
			end
			OP_TAKE: begin
				if (box_marked[s]) begin
					rep.dirty = 1'b1;
					rep.rx    = box_lo_x[s];
					rep.ry    = box_lo_y[s];
					rep.rw    = SIZE_W'(int'(box_hi_x[s]) - int'(box_lo_x[s]));
					rep.rh    = SIZE_W'(int'(box_hi_y[s]) - int'(box_lo_y[s]));
				end
				empty_box(s);
			end
			OP_CLEAR: empty_box(s);
			default: ;
		endcase
		return rep;
	endfunction

	function automatic request_t make_request(logic [OP_W-1:0] op, int s, int x, int y,
			int w, int h);
		request_t req;
		req.op   = op;
		req.slot = SLOT_W'(s);
		req.x    = COORD_W'(x);
		req.y    = COORD_W'(y);
		req.w    = COORD_W'(w);
		req.h    = COORD_W'(h);
		return req;
	endfunction

	function automatic void add_row(logic [OP_W-1:0] op, int s, int x, int y, int w, int h,
			bit typed = 1'b0, report_t rep = '0);
		table_row_t row;
		row.req   = make_request(op, s, x, y, w, h);
		row.typed = typed;
		row.rep   = rep;
		stimulus_table.push_back(row);
	endfunction

	// Coordinates: mostly moderate, with full-range values and both extremes.
	function automatic int random_coord();
		case ($urandom_range(0, 5))
			0: return $signed(16'($urandom()));
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			2: return $urandom_range(0, 128) - 64;
			default: return $urandom_range(0, 2000) - 500;
		endcase
	endfunction

	// Extents: mostly positive, sometimes any 16-bit value so that marks get dropped.
	function automatic int random_extent();
		case ($urandom_range(0, 9))
			0, 1: return $signed(16'($urandom()));
			2: return 32767;
			3: return $urandom_range(1, 32767);
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	function automatic request_t random_mark(int s);
		return make_request(OP_MARK, s, random_coord(), random_coord(), random_extent(),
			random_extent());
	endfunction

	function automatic request_t random_noise();
		request_t    req;
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		req = raw[$bits(request_t)-1:0];
		return req;
	endfunction

	function automatic void check_field(string name, longint expv, longint actv);
		if (expv != actv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			mismatches++;
		end
	endfunction

	// Offers one request in the sender's burst pattern and records its expected report.
	task automatic send_request(request_t req, bit typed = 1'b0, report_t rep = '0);
		report_t predicted;
		int      gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid  = 1'b1;
		operation = req.op;
		slot      = req.slot;
		pos_x     = req.x;
		pos_y     = req.y;
		width     = req.w;
		height    = req.h;
		do @(posedge clk); while (!in_ready);
		predicted = predict_report(req);
		pending_reports.push_back(typed ? rep : predicted);
		requests_accepted++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain_reports();
		in_valid   = 1'b0;
		burst_left = 0;
		while (pending_reports.size() != 0) @(negedge clk);
	endtask

	// Result checker: each accepted report against the oldest expectation.
	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("report received with no request outstanding");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("was_dirty", want.dirty, was_dirty);
				check_field("rect_x", $signed(want.rx), rect_x);
				check_field("rect_y", $signed(want.ry), rect_y);
				check_field("rect_width", want.rw, rect_width);
				check_field("rect_height", want.rh, rect_height);
			end
		end
	end

	// Receiver: random stall phases, plus one long hold-off while requests keep coming.
	initial begin
		rx_mode_t rx_mode;
		int       phase_left;
		int       rx_tick;
		rx_mode    = RX_FREE;
		phase_left = 0;
		rx_tick    = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_tick++;
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (!hold_done && requests_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready = 1'b0;
			end else begin
				if (phase_left == 0) begin
					rx_mode    = rx_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(16, 96);
				end
				phase_left--;
				case (rx_mode)
					RX_FREE:     out_ready = 1'b1;
					RX_HALF:     out_ready = 1'($urandom_range(0, 1));
					RX_SPARSE:   out_ready = ($urandom_range(0, 3) == 0);
					RX_PERIODIC: out_ready = (rx_tick % 3 != 0);
				endcase
			end
		end
	end

	// Watchdog: ends the run when nothing is accepted for too long.
	always @(posedge clk) begin
		int idle_cycles;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	// Stimulus: directed table, then random traffic of mark sequences ending in a take, single takes, clears and noise.
	initial begin
		int       total;
		int       s;
		int       n;
		bit       drained_mid;
		drained_mid = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) empty_box(i);

		// Fresh table, extreme corners and sizes, dropped marks, clear and the unused code.
		add_row(OP_TAKE, 0, 0, 0, 0, 0, 1'b1, '0);
		add_row(OP_MARK, 1, -32768, -32768, 32767, 32767, 1'b1, '0);
		add_row(OP_TAKE, 1, 0, 0, 0, 0, 1'b1,
			report_t'{1'b1, -18'sd32768, -18'sd32768, 17'd32767, 17'd32767});
		add_row(OP_TAKE, 1, 0, 0, 0, 0, 1'b1, '0);
		add_row(OP_MARK, 2, 32767, 32767, 32767, 32767, 1'b1, '0);
		add_row(OP_MARK, 2, -32768, -32768, 1, 1, 1'b1, '0);
		add_row(OP_TAKE, 2, 0, 0, 0, 0, 1'b1,
			report_t'{1'b1, -18'sd32768, -18'sd32768, 17'd98302, 17'd98302});
		add_row(OP_MARK, 3, 7, 7, 0, 5, 1'b1, '0);
		add_row(OP_MARK, 3, 7, 7, 5, 0, 1'b1, '0);
		add_row(OP_MARK, 3, -1, -1, -32768, -32768, 1'b1, '0);
		add_row(OP_MARK, 3, 100, 100, -1, 100, 1'b1, '0);
		add_row(OP_TAKE, 3, 0, 0, 0, 0, 1'b1, '0);
		add_row(OP_MARK, 4, 10, 20, 30, 40);
		add_row(OP_CLEAR, 4, 0, 0, 0, 0, 1'b1, '0);
		add_row(OP_TAKE, 4, 0, 0, 0, 0, 1'b1, '0);
		add_row(OP_NONE, 5, -1, -1, -1, -1, 1'b1, '0);
		add_row(OP_TAKE, 5, 0, 0, 0, 0, 1'b1, '0);
		add_row(OP_MARK, 15, 100, 200, 1, 1);
		add_row(OP_MARK, 15, 50, 300, 10, 10);
		add_row(OP_TAKE, 15, 0, 0, 0, 0);
		add_row(OP_MARK, 0, 0, 0, 32767, 32767);
		add_row(OP_TAKE, 0, 0, 0, 0, 0);
		add_row(OP_MARK, 6, 5, 5, 3, 3);
		add_row(OP_NONE, 6, 0, 0, 0, 0);
		add_row(OP_TAKE, 6, 0, 0, 0, 0);

		// Hold reset, then release it at a falling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stimulus_table[i])
			send_request(stimulus_table[i].req, stimulus_table[i].typed, stimulus_table[i].rep);
		drain_reports();

		total = stimulus_table.size() + RANDOM_ITEMS;
		while (requests_accepted < total) begin
			if (!drained_mid && requests_accepted >= DRAIN_AT) begin
				drained_mid = 1'b1;
				drain_reports();
			end
			case ($urandom_range(0, 9))
				7: send_request(make_request(OP_TAKE, $urandom_range(0, 15), 0, 0, 0, 0));
				8: send_request(make_request(OP_CLEAR, $urandom_range(0, 15), 0, 0, 0, 0));
				9: send_request(random_noise());
				default: begin
					// Build up a box on one slot, with stray requests in between.
					s = $urandom_range(0, 15);
					n = $urandom_range(1, 5);
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(0, 4) == 0) send_request(random_noise());
						send_request(random_mark(s));
					end
					if ($urandom_range(0, 5) == 0)
						send_request(make_request(OP_CLEAR, s, 0, 0, 0, 0));
					send_request(make_request(OP_TAKE, s, 0, 0, 0, 0));
				end
			endcase
		end

		// Let the last reports arrive and wait out a quiet tail before the verdict.
		in_valid = 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
rtl/core/drt_pkg.sv
rtl/core/drt_ram.sv
rtl/core/drt_ctrl.sv
rtl/core/drt_datapath.sv
rtl/core/dirty_rect_tracker_top.sv
verif/dirty_rect_tracker_tb.sv
